// File: rtl/rational_arith_unit_assert.svh
// ---------------------------------------------------------------------------
// rational_arith_unit_assert.svh
// assertion macros used by the port checker of the rational arithmetic unit
// ---------------------------------------------------------------------------
`ifndef RATIONAL_ARITH_UNIT_ASSERT_SVH
`define RATIONAL_ARITH_UNIT_ASSERT_SVH

// same-cycle implication, held off during reset
`define RAU_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define RAU_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also covers the reset cycles
`define RAU_ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/rau_pkg.sv
// ---------------------------------------------------------------------------
// rau_pkg
// widths, codes, unit request types and range checks of the rational unit
// ---------------------------------------------------------------------------
`default_nettype none

package rau_pkg;

    localparam int RAU_WORD_BITS = 32;
    localparam int FIELD_BITS    = 32;
    localparam int WIDE_BITS     = 64;
    localparam int SHIFT_BITS    = 6;

    typedef logic [WIDE_BITS-1:0]  wide_t;
    typedef logic [FIELD_BITS-1:0] mag_t;

    typedef enum logic [1:0] {
        KIND_ADD = 2'd0,
        KIND_SUB = 2'd1,
        KIND_MUL = 2'd2,
        KIND_DIV = 2'd3
    } kind_t;

    // request to a shared multi-cycle unit
    typedef struct packed {
        logic  start;
        wide_t op_x;
        wide_t op_y;
    } unit_req_t;

    // response from a shared multi-cycle unit
    typedef struct packed {
        logic  done;
        wide_t value;
    } unit_rsp_t;

    // does a sign and magnitude value fit a signed word of nbits
    function automatic logic fits_bits(input logic neg, input wide_t mag, input int nbits);
        logic [WIDE_BITS:0] half;
        logic [WIDE_BITS:0] m;
        half = (WIDE_BITS+1)'(1) << (nbits - 1);
        m    = {1'b0, mag};
        if (mag == '0) begin
            return 1'b1;
        end
        return neg ? (m <= half) : (m < half);
    endfunction

endpackage

`default_nettype wire

// File: rtl/rau_div.sv
// ---------------------------------------------------------------------------
// rau_div
// restoring shift-subtract divider, one quotient bit a cycle
// ---------------------------------------------------------------------------
`default_nettype none

module rau_div
    import rau_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire unit_req_t req,
    output unit_rsp_t      rsp
);

    logic                  busy_reg;
    logic                  done_reg;
    logic [SHIFT_BITS-1:0] cnt_reg;
    wide_t                 quo_reg;
    wide_t                 rem_reg;
    wide_t                 den_reg;

    logic [WIDE_BITS:0]    trial;
    logic                  take;
    wide_t                 rem_next;

    // trial subtract of the divisor from the shifted remainder
    always_comb begin
        trial    = {rem_reg, quo_reg[WIDE_BITS-1]};
        take     = trial >= {1'b0, den_reg};
        rem_next = take ? WIDE_BITS'(trial - {1'b0, den_reg}) : trial[WIDE_BITS-1:0];
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == {SHIFT_BITS{1'b1}}) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (req.start) begin
            quo_reg <= req.op_x;
            den_reg <= req.op_y;
            rem_reg <= '0;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[WIDE_BITS-2:0], take};
            rem_reg <= rem_next;
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.value = quo_reg;

endmodule

`default_nettype wire

// File: rtl/rau_gcd.sv
// ---------------------------------------------------------------------------
// rau_gcd
// binary gcd, one subtract or shift step a cycle
// ---------------------------------------------------------------------------
`default_nettype none

module rau_gcd
    import rau_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire unit_req_t req,
    output unit_rsp_t      rsp
);

    logic                  busy_reg;
    logic                  done_reg;
    logic [SHIFT_BITS-1:0] k_reg;
    wide_t                 x_reg;
    wide_t                 y_reg;
    wide_t                 res_reg;

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && (x_reg == '0 || y_reg == '0)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // one step of the reduction
    always_ff @(posedge aclk) begin
        if (req.start) begin
            x_reg <= req.op_x;
            y_reg <= req.op_y;
            k_reg <= '0;
        end else if (busy_reg) begin
            if (x_reg == '0) begin
                res_reg <= y_reg << k_reg;
            end else if (y_reg == '0) begin
                res_reg <= x_reg << k_reg;
            end else if (!x_reg[0] && !y_reg[0]) begin
                x_reg <= x_reg >> 1;
                y_reg <= y_reg >> 1;
                k_reg <= k_reg + 1'b1;
            end else if (!x_reg[0]) begin
                x_reg <= x_reg >> 1;
            end else if (!y_reg[0]) begin
                y_reg <= y_reg >> 1;
            end else if (x_reg >= y_reg) begin
                x_reg <= x_reg - y_reg;
            end else begin
                y_reg <= y_reg - x_reg;
            end
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.value = res_reg;

endmodule

`default_nettype wire

// File: rtl/rational_arith_unit.sv
// ---------------------------------------------------------------------------
// rational_arith_unit
// add, subtract, multiply or divide two signed fractions, result gcd-reduced
// ---------------------------------------------------------------------------
// Usage:
//   s_ channel: one beat carries the operation in s_tuser and the four
//   operand words in s_tdata. m_ channel: one beat per operation with the
//   reduced fraction in m_tdata and the valid flag in m_tuser. An invalid
//   result (overflow or zero denominator) is sent as 0/0 with the flag low.
//   A sequencer steps a shared binary gcd unit (one step a cycle), a
//   shared divider and one 32x32 multiplier with a registered product.
//   Add and subtract take at most two gcds, four divides and three
//   products; multiply and divide take at most three gcds, six divides
//   and two products. Operands invalid at the start go straight to the
//   output register without using any unit. s_tready is high only while
//   no operation is in work; one result may wait in the output register
//   while the next beat is taken, and the sequencer holds its last step
//   while that register is full and m_tready is low. Reset clears the
//   sequencer and drops m_tvalid; no clearing pass is needed.
// ---------------------------------------------------------------------------
`default_nettype none

module rational_arith_unit
    import rau_pkg::*;
#(
    parameter int WORD_BITS = RAU_WORD_BITS
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // a_num, a_den, b_num, b_den from the lowest bit up
    input  wire logic [127:0] s_tdata,
    // kind
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // res_num, res_den from the lowest bit up
    output logic [63:0]       m_tdata,
    // res_ok
    output logic [0:0]        m_tuser
);

    typedef enum logic [20:0] {
        ST_IDLE  = 21'h000001,
        ST_G_LCM = 21'h000002,
        ST_D_QA  = 21'h000004,
        ST_M_LCM = 21'h000008,
        ST_D_QB  = 21'h000010,
        ST_M_PA  = 21'h000020,
        ST_M_PB  = 21'h000040,
        ST_SUM   = 21'h000080,
        ST_G_X   = 21'h000100,
        ST_D_XN  = 21'h000200,
        ST_D_YD  = 21'h000400,
        ST_G_Y   = 21'h000800,
        ST_D_XD  = 21'h001000,
        ST_D_YN  = 21'h002000,
        ST_M_RN  = 21'h004000,
        ST_M_RD  = 21'h008000,
        ST_CHK   = 21'h010000,
        ST_G_RED = 21'h020000,
        ST_D_RN  = 21'h040000,
        ST_D_RD  = 21'h080000,
        ST_FIN   = 21'h100000
    } state_t;

    state_t      state_reg, state_next;
    logic        launched_reg, launched_next;

    mag_t        an_mag_reg, ad_mag_reg, bn_mag_reg, bd_mag_reg;
    logic        sa_reg, sb_reg, ok_reg, rneg_reg;
    wide_t       g_reg, lcm_reg, pa_reg, pb_reg, rnum_reg, rden_reg, prod_reg;

    logic        m_valid_reg;
    mag_t        m_num_reg, m_den_reg;
    logic        m_ok_reg;

    unit_req_t   gcd_req, div_req;
    unit_rsp_t   gcd_rsp, div_rsp;

    logic        is_gcd, is_div, is_mul, step_done, accept, out_load;
    mag_t        mul_a, mul_b;

    // operand decode
    logic        an_neg, ad_neg, bnr_neg, bdr_neg, bn_neg_e, bd_neg_e;
    mag_t        an_mag, ad_mag, bnr_mag, bdr_mag, bn_mag_e, bd_mag_e;
    logic        in_ok, start_ok;
    logic        fin_ok;
    kind_t       kind_in;

    assign kind_in = kind_t'(s_tuser);

    always_comb begin
        an_neg  = s_tdata[31];
        ad_neg  = s_tdata[63];
        bnr_neg = s_tdata[95];
        bdr_neg = s_tdata[127];
        an_mag  = an_neg  ? (~s_tdata[31:0]   + 1'b1) : s_tdata[31:0];
        ad_mag  = ad_neg  ? (~s_tdata[63:32]  + 1'b1) : s_tdata[63:32];
        bnr_mag = bnr_neg ? (~s_tdata[95:64]  + 1'b1) : s_tdata[95:64];
        bdr_mag = bdr_neg ? (~s_tdata[127:96] + 1'b1) : s_tdata[127:96];
        in_ok = fits_bits(an_neg,  WIDE_BITS'(an_mag),  WORD_BITS)
             && fits_bits(ad_neg,  WIDE_BITS'(ad_mag),  WORD_BITS)
             && fits_bits(bnr_neg, WIDE_BITS'(bnr_mag), WORD_BITS)
             && fits_bits(bdr_neg, WIDE_BITS'(bdr_mag), WORD_BITS);
        // divide swaps the second operand, subtract flips its sign
        if (kind_in == KIND_DIV) begin
            bn_neg_e = bdr_neg;
            bn_mag_e = bdr_mag;
            bd_neg_e = bnr_neg;
            bd_mag_e = bnr_mag;
        end else begin
            bn_neg_e = bnr_neg ^ (kind_in == KIND_SUB);
            bn_mag_e = bnr_mag;
            bd_neg_e = bdr_neg;
            bd_mag_e = bdr_mag;
        end
        start_ok = in_ok && (ad_mag != '0) && (bd_mag_e != '0);
    end

    // unit class of the current step
    always_comb begin
        is_gcd = 1'b0;
        is_div = 1'b0;
        is_mul = 1'b0;
        unique case (state_reg)
            ST_G_LCM, ST_G_X, ST_G_Y, ST_G_RED: is_gcd = 1'b1;
            ST_D_QA, ST_D_QB, ST_D_XN, ST_D_YD,
            ST_D_XD, ST_D_YN, ST_D_RN, ST_D_RD: is_div = 1'b1;
            ST_M_LCM, ST_M_PA, ST_M_PB, ST_M_RN, ST_M_RD: is_mul = 1'b1;
            default: ;
        endcase
        step_done = launched_reg
                 && (is_mul || (is_gcd && gcd_rsp.done) || (is_div && div_rsp.done));
    end

    // unit operands
    always_comb begin
        gcd_req.start = is_gcd && !launched_reg;
        div_req.start = is_div && !launched_reg;
        gcd_req.op_x  = WIDE_BITS'(ad_mag_reg);
        gcd_req.op_y  = WIDE_BITS'(bd_mag_reg);
        div_req.op_x  = WIDE_BITS'(ad_mag_reg);
        div_req.op_y  = g_reg;
        mul_a         = ad_mag_reg;
        mul_b         = bd_mag_reg;
        unique case (state_reg)
            ST_G_X: begin
                gcd_req.op_x = WIDE_BITS'(an_mag_reg);
            end
            ST_G_Y: begin
                gcd_req.op_y = WIDE_BITS'(bn_mag_reg);
            end
            ST_G_RED: begin
                gcd_req.op_x = rnum_reg;
                gcd_req.op_y = rden_reg;
            end
            ST_D_QB, ST_D_YD: div_req.op_x = WIDE_BITS'(bd_mag_reg);
            ST_D_XN: div_req.op_x = WIDE_BITS'(an_mag_reg);
            ST_D_YN: div_req.op_x = WIDE_BITS'(bn_mag_reg);
            ST_D_RN: div_req.op_x = rnum_reg;
            ST_D_RD: div_req.op_x = rden_reg;
            ST_M_PA: mul_a = an_mag_reg;
            // second numerator scales by the first denominator over the gcd
            ST_M_PB: begin
                mul_a = bn_mag_reg;
                mul_b = ad_mag_reg;
            end
            ST_M_RN: begin
                mul_a = an_mag_reg;
                mul_b = bn_mag_reg;
            end
            default: ;
        endcase
    end

    rau_gcd u_gcd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (gcd_req),
        .rsp     (gcd_rsp)
    );

    rau_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign accept   = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_FIN) && (!m_valid_reg || m_tready);
    assign fin_ok   = ok_reg
                   && fits_bits(rneg_reg, rnum_reg, WORD_BITS)
                   && fits_bits(rneg_reg, rnum_reg, FIELD_BITS)
                   && fits_bits(1'b0, rden_reg, WORD_BITS)
                   && fits_bits(1'b0, rden_reg, FIELD_BITS);

    // sequencer
    always_comb begin
        state_next    = state_reg;
        launched_next = launched_reg;
        if ((is_gcd || is_div || is_mul) && !launched_reg) begin
            launched_next = 1'b1;
        end else if (step_done) begin
            launched_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (!start_ok) begin
                        state_next = ST_FIN;
                    end else if (kind_in == KIND_MUL || kind_in == KIND_DIV) begin
                        state_next = ST_G_X;
                    end else begin
                        state_next = ST_G_LCM;
                    end
                end
            end
            ST_G_LCM: if (step_done) state_next = ST_D_QA;
            ST_D_QA:  if (step_done) state_next = ST_M_LCM;
            ST_M_LCM: if (step_done) state_next = ST_D_QB;
            ST_D_QB:  if (step_done) state_next = ST_M_PA;
            ST_M_PA:  if (step_done) state_next = ST_M_PB;
            ST_M_PB:  if (step_done) state_next = ST_SUM;
            ST_SUM:   state_next = ST_CHK;
            ST_G_X:   if (step_done) state_next = ST_D_XN;
            ST_D_XN:  if (step_done) state_next = ST_D_YD;
            ST_D_YD:  if (step_done) state_next = ST_G_Y;
            ST_G_Y:   if (step_done) state_next = ST_D_XD;
            ST_D_XD:  if (step_done) state_next = ST_D_YN;
            ST_D_YN:  if (step_done) state_next = ST_M_RN;
            ST_M_RN:  if (step_done) state_next = ST_M_RD;
            ST_M_RD:  if (step_done) state_next = ST_CHK;
            ST_CHK: begin
                if (!ok_reg || rnum_reg == '0) begin
                    state_next = ST_FIN;
                end else begin
                    state_next = ST_G_RED;
                end
            end
            ST_G_RED: if (step_done) state_next = ST_D_RN;
            ST_D_RN:  if (step_done) state_next = ST_D_RD;
            ST_D_RD:  if (step_done) state_next = ST_FIN;
            ST_FIN:   if (out_load) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            launched_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            launched_reg <= launched_next;
        end
    end

    // shared multiplier, registered product
    always_ff @(posedge aclk) begin
        prod_reg <= WIDE_BITS'(mul_a) * WIDE_BITS'(mul_b);
    end

    // working registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                an_mag_reg <= an_mag;
                ad_mag_reg <= ad_mag;
                bn_mag_reg <= bn_mag_e;
                bd_mag_reg <= bd_mag_e;
                sa_reg     <= (an_neg != ad_neg) && (an_mag != '0);
                sb_reg     <= (bn_neg_e != bd_neg_e) && (bn_mag_e != '0);
                ok_reg     <= start_ok;
            end
            ST_G_LCM, ST_G_X, ST_G_Y, ST_G_RED: begin
                if (step_done) g_reg <= gcd_rsp.value;
            end
            ST_D_QA, ST_D_XD: begin
                if (step_done) ad_mag_reg <= div_rsp.value[FIELD_BITS-1:0];
            end
            ST_D_QB, ST_D_YD: begin
                if (step_done) bd_mag_reg <= div_rsp.value[FIELD_BITS-1:0];
            end
            ST_D_XN: begin
                if (step_done) an_mag_reg <= div_rsp.value[FIELD_BITS-1:0];
            end
            ST_D_YN: begin
                if (step_done) bn_mag_reg <= div_rsp.value[FIELD_BITS-1:0];
            end
            ST_D_RN: begin
                if (step_done) rnum_reg <= div_rsp.value;
            end
            ST_D_RD: begin
                if (step_done) rden_reg <= div_rsp.value;
            end
            ST_M_LCM: begin
                if (step_done) lcm_reg <= prod_reg;
            end
            ST_M_PA: begin
                if (step_done) pa_reg <= prod_reg;
            end
            ST_M_PB: begin
                if (step_done) pb_reg <= prod_reg;
            end
            ST_SUM: begin
                // signed sum of the scaled numerators over the lcm
                rden_reg <= lcm_reg;
                if (sa_reg == sb_reg) begin
                    rnum_reg <= pa_reg + pb_reg;
                    rneg_reg <= sa_reg;
                    ok_reg   <= ok_reg && fits_bits(sa_reg, pa_reg + pb_reg, WORD_BITS)
                             && fits_bits(1'b0, lcm_reg, WORD_BITS)
                             && fits_bits(sa_reg, pa_reg, WORD_BITS)
                             && fits_bits(sb_reg, pb_reg, WORD_BITS);
                end else if (pa_reg >= pb_reg) begin
                    rnum_reg <= pa_reg - pb_reg;
                    rneg_reg <= sa_reg;
                    ok_reg   <= ok_reg && fits_bits(sa_reg, pa_reg - pb_reg, WORD_BITS)
                             && fits_bits(1'b0, lcm_reg, WORD_BITS)
                             && fits_bits(sa_reg, pa_reg, WORD_BITS)
                             && fits_bits(sb_reg, pb_reg, WORD_BITS);
                end else begin
                    rnum_reg <= pb_reg - pa_reg;
                    rneg_reg <= sb_reg;
                    ok_reg   <= ok_reg && fits_bits(sb_reg, pb_reg - pa_reg, WORD_BITS)
                             && fits_bits(1'b0, lcm_reg, WORD_BITS)
                             && fits_bits(sa_reg, pa_reg, WORD_BITS)
                             && fits_bits(sb_reg, pb_reg, WORD_BITS);
                end
            end
            ST_M_RN: begin
                if (step_done) begin
                    rnum_reg <= prod_reg;
                    rneg_reg <= sa_reg ^ sb_reg;
                    ok_reg   <= ok_reg && fits_bits(sa_reg ^ sb_reg, prod_reg, WORD_BITS);
                end
            end
            ST_M_RD: begin
                if (step_done) begin
                    rden_reg <= prod_reg;
                    ok_reg   <= ok_reg && fits_bits(1'b0, prod_reg, WORD_BITS);
                end
            end
            ST_CHK: begin
                // zero result goes out as 0/1
                if (rnum_reg == '0) begin
                    rneg_reg <= 1'b0;
                    rden_reg <= WIDE_BITS'(1);
                end
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_ok_reg <= fin_ok;
            if (fin_ok) begin
                m_num_reg <= rneg_reg ? (~rnum_reg[FIELD_BITS-1:0] + 1'b1)
                                      : rnum_reg[FIELD_BITS-1:0];
                m_den_reg <= rden_reg[FIELD_BITS-1:0];
            end else begin
                m_num_reg <= '0;
                m_den_reg <= '0;
            end
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_den_reg, m_num_reg};
    assign m_tuser  = m_ok_reg;

endmodule

`default_nettype wire

// File: rtl/rau_checker.sv
// ---------------------------------------------------------------------------
// rau_checker
// port-level checks of the rational arithmetic unit, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none

`include "rational_arith_unit_assert.svh"

module rau_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [63:0]  m_tdata,
    input wire logic [0:0]   m_tuser
);

    // a stalled result beat holds
    `RAU_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result beat changed while stalled")

    // an invalid result is sent as zeros
    `RAU_ASSERT_NOW(a_bad_zero, aclk, aresetn, m_tvalid && !m_tuser[0], m_tdata == 64'd0, "invalid result carries data")

    // a valid result has a positive denominator
    `RAU_ASSERT_NOW(a_den_pos, aclk, aresetn, m_tvalid && m_tuser[0], !m_tdata[63] && m_tdata[63:32] != 32'd0, "valid result with non-positive denominator")

    // an accepted operation keeps the input closed in the next cycle
    `RAU_ASSERT_NEXT(a_busy, aclk, aresetn, s_tvalid && s_tready, !s_tready, "input reopened right after a beat")

    // reset drops the result channel
    `RAU_ASSERT_ALWAYS(a_rst, aclk, !aresetn, !m_tvalid, "result valid after reset")

endmodule

bind rational_arith_unit rau_checker u_rau_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// File: sim/rational_arith_unit_checker.sv
// ---------------------------------------------------------------------------
// rational_arith_unit_checker
// watches both channels of the rational unit, works out the reduced fraction
// for every accepted operation beat and compares it with each result beat
// ---------------------------------------------------------------------------
`default_nettype none

module rational_arith_unit_checker
    import rau_pkg::*;
#(
    parameter int WORD_BITS = RAU_WORD_BITS
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [127:0] s_tdata,
    input  wire logic [1:0]   s_tuser,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [63:0]  m_tdata,
    input  wire logic [0:0]   m_tuser,
    output int                fail_count,
    output int                pending_count
);

    typedef struct packed {
        logic [31:0] num;
        logic [31:0] den;
        logic        ok;
    } fraction_t;

    fraction_t expected_fractions[$];

    // sign and magnitude fit test against a signed word of nbits
    function automatic bit word_fits(bit neg, longint unsigned mag, int nbits);
        longint unsigned half;
        half = 64'd1 << (nbits - 1);
        if (mag == 0) return 1'b1;
        return neg ? (mag <= half) : (mag <= half - 1);
    endfunction

    function automatic longint unsigned euclid_gcd(longint unsigned x, longint unsigned y);
        longint unsigned t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // exact fraction arithmetic with overflow checks at the word width
    function automatic fraction_t reduce_fraction(kind_t kind, logic [127:0] ops);
        fraction_t       r;
        bit              neg[4];
        longint unsigned mag[4];
        bit              ok, sa, sb, rneg, tn;
        longint unsigned tm, g, lcm, pa, pb, rnum, rden, g1, g2;
        ok   = 1'b1;
        rneg = 1'b0;
        rnum = 0;
        rden = 1;
        for (int i = 0; i < 4; i++) begin
            logic [31:0] w;
            w      = ops[32*i +: 32];
            neg[i] = w[31];
            mag[i] = w[31] ? longint'(32'(-w)) : longint'(w);
            if (w == 32'h8000_0000) mag[i] = 64'h8000_0000;
            if (!word_fits(neg[i], mag[i], WORD_BITS)) ok = 1'b0;
        end
        if (kind == KIND_SUB) neg[2] = !neg[2];
        if (kind == KIND_DIV) begin
            tn = neg[2]; tm = mag[2];
            neg[2] = neg[3]; mag[2] = mag[3];
            neg[3] = tn; mag[3] = tm;
        end
        if (mag[1] == 0 || mag[3] == 0) ok = 1'b0;
        if (ok) begin
            sa = (neg[0] != neg[1]) && mag[0] != 0;
            sb = (neg[2] != neg[3]) && mag[2] != 0;
            if (kind == KIND_ADD || kind == KIND_SUB) begin
                g   = euclid_gcd(mag[1], mag[3]);
                lcm = (mag[1] / g) * mag[3];
                if (!word_fits(1'b0, lcm, WORD_BITS)) ok = 1'b0;
                pa = mag[0] * (lcm / mag[1]);
                pb = mag[2] * (lcm / mag[3]);
                if (!word_fits(sa, pa, WORD_BITS)) ok = 1'b0;
                if (!word_fits(sb, pb, WORD_BITS)) ok = 1'b0;
                if (sa == sb) begin
                    rnum = pa + pb; rneg = sa;
                end else if (pa >= pb) begin
                    rnum = pa - pb; rneg = sa;
                end else begin
                    rnum = pb - pa; rneg = sb;
                end
                if (!word_fits(rneg, rnum, WORD_BITS)) ok = 1'b0;
                rden = lcm;
            end else begin
                g1   = euclid_gcd(mag[0], mag[3]);
                g2   = euclid_gcd(mag[1], mag[2]);
                rneg = sa != sb;
                rnum = (mag[0] / g1) * (mag[2] / g2);
                rden = (mag[1] / g2) * (mag[3] / g1);
                if (!word_fits(rneg, rnum, WORD_BITS)) ok = 1'b0;
                if (!word_fits(1'b0, rden, WORD_BITS)) ok = 1'b0;
            end
        end
        if (ok) begin
            if (rnum == 0) begin
                rneg = 1'b0; rden = 1;
            end else begin
                g = euclid_gcd(rnum, rden);
                rnum = rnum / g;
                rden = rden / g;
            end
            if (!word_fits(rneg, rnum, WORD_BITS) || !word_fits(rneg, rnum, 32)) ok = 1'b0;
            if (!word_fits(1'b0, rden, WORD_BITS) || !word_fits(1'b0, rden, 32)) ok = 1'b0;
        end
        if (ok) begin
            r.num = rneg ? 32'(-rnum) : 32'(rnum);
            r.den = 32'(rden);
            r.ok  = 1'b1;
        end else begin
            r = '0;
        end
        return r;
    endfunction

    assign pending_count = expected_fractions.size();

    // predict on every operation beat, compare on every result beat
    always @(posedge aclk) begin
        fraction_t want, got;
        if (!aresetn) begin
            fail_count <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_fractions.push_back(reduce_fraction(kind_t'(s_tuser), s_tdata));
            end
            if (m_tvalid && m_tready) begin
                got = {m_tdata[31:0], m_tdata[63:32], m_tuser[0]};
                if (expected_fractions.size() == 0) begin
                    $display("%0t: unexpected result beat num=%h den=%h ok=%b",
                             $time, got.num, got.den, got.ok);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_fractions.pop_front();
                    if (want != got) begin
                        $display("%0t: mismatch expected %h/%h ok=%b actual %h/%h ok=%b",
                                 $time, want.num, want.den, want.ok,
                                 got.num, got.den, got.ok);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: sim/rational_arith_unit_tb.sv
// ---------------------------------------------------------------------------
// rational_arith_unit_tb
// drives directed and random fraction operations in bursts, stalls the
// result side and reports the verdict from the checker's failure count
// ---------------------------------------------------------------------------
`default_nettype none

module rational_arith_unit_tb;
    import rau_pkg::*;

    localparam int RANDOM_BEATS = 1600;
    localparam int IDLE_LIMIT   = 20000;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;
    logic [0:0]   m_tuser;
    int           fail_count;
    int           pending_count;
    int           idle_cycles;

    rational_arith_unit i_dut (.*);

    rational_arith_unit_checker i_checker (.*);

    // clock
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // result side stall pattern: long ready runs mixed with stall runs
    initial begin
        int run;
        m_tready = 1'b0;
        forever begin
            run = $urandom_range(1, 40);
            m_tready = ($urandom_range(0, 2) != 0);
            repeat (run) @(negedge aclk);
        end
    end

    // watchdog on cycles without any accepted beat
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // word biased towards edge values and small magnitudes
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'(int'($urandom_range(0, 4)) - 2);
            3: return $urandom();
            4: return 32'(-int'($urandom_range(1, 5000)));
            default: return 32'($urandom_range(1, 5000));
        endcase
    endfunction

    // hold one beat until the block takes it
    task automatic send_beat(kind_t kind, logic [31:0] an, logic [31:0] ad,
                             logic [31:0] bn, logic [31:0] bd);
        s_tuser  <= kind;
        s_tdata  <= {bd, bn, ad, an};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    initial begin
        int burst;
        int sent;
        idle_cycles = 0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = KIND_ADD;
        repeat (2) @(negedge aclk);
        aresetn = 1'b1;

        // directed: every operation, zero denominators, zero result, extremes
        send_beat(KIND_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
        send_beat(KIND_SUB, 32'd1, 32'd2, 32'd1, 32'd2);
        send_beat(KIND_MUL, -32'd4, 32'd6, 32'd3, -32'd8);
        send_beat(KIND_DIV, 32'd3, 32'd5, -32'd9, 32'd10);
        send_beat(KIND_ADD, 32'd1, 32'd0, 32'd1, 32'd1);
        send_beat(KIND_SUB, 32'd1, 32'd1, 32'd1, 32'd0);
        send_beat(KIND_MUL, 32'd1, 32'd1, 32'd1, 32'd0);
        send_beat(KIND_DIV, 32'd1, 32'd1, 32'd0, 32'd5);
        send_beat(KIND_DIV, 32'd1, 32'd0, 32'd2, 32'd5);
        send_beat(KIND_MUL, 32'd0, 32'd7, 32'd5, 32'd3);
        send_beat(KIND_ADD, 32'h8000_0000, 32'd1, 32'd0, 32'd1);
        send_beat(KIND_SUB, 32'd0, 32'd1, 32'h8000_0000, 32'd1);
        send_beat(KIND_MUL, 32'd1, 32'h8000_0000, 32'd1, 32'd1);
        send_beat(KIND_MUL, 32'h8000_0000, 32'd1, -32'd1, 32'd1);
        send_beat(KIND_ADD, 32'h7fff_ffff, 32'd1, 32'd1, 32'd1);
        send_beat(KIND_ADD, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
        send_beat(KIND_ADD, 32'd1, 32'h7fff_ffff, 32'd1, 32'h7fff_fffe);
        send_beat(KIND_DIV, 32'h7fff_ffff, -32'd1, 32'h8000_0000, -32'd1);
        send_beat(KIND_MUL, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        send_beat(KIND_SUB, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_beat(KIND_DIV, 32'h5555_5555, 32'haaaa_aaaa, 32'haaaa_aaaa, 32'h5555_5555);

        // random: bursts with gaps of random length, sometimes none, between them
        sent = 0;
        while (sent < RANDOM_BEATS) begin
            burst = $urandom_range(1, 12);
            repeat (burst) begin
                send_beat(kind_t'($urandom_range(0, 3)), pick_word(), pick_word(),
                          pick_word(), pick_word());
                sent++;
            end
            s_tvalid <= 1'b0;
            repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20)) @(negedge aclk);
        end
        s_tvalid <= 1'b0;

        while (pending_count != 0) @(negedge aclk);
        repeat (1000) @(negedge aclk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: rational_arith_unit.f
+incdir+rtl
rtl/rau_pkg.sv
rtl/rau_div.sv
rtl/rau_gcd.sv
rtl/rational_arith_unit.sv
rtl/rau_checker.sv
sim/rational_arith_unit_checker.sv
sim/rational_arith_unit_tb.sv
